@@ rtl/core/tdpt_pkg.sv @@
// tdpt_pkg: shared types for the trial division prime test
`timescale 1ns / 1ps

package tdpt_pkg;

   // command from the sequencer to the shared divider
   typedef struct packed {
      logic start;
   } tdpt_div_ctrl_type;

   // report from the shared divider back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } tdpt_div_status_type;

endpackage

@@ rtl/core/tdpt_divider.sv @@
// tdpt_divider: shared unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tdpt_divider #(
   parameter int WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tdpt_pkg::tdpt_div_ctrl_type     ctrl,
   input  logic [WIDTH-1:0]                dividend,
   input  logic [WIDTH-1:0]                divisor,
   output tdpt_pkg::tdpt_div_status_type   status,
   output logic [WIDTH-1:0]                quotient,
   output logic [WIDTH-1:0]                remainder
);
   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   div_state_type      state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [WIDTH-1:0]   rem_ff;
   logic [WIDTH-1:0]   quo_ff;
   logic [WIDTH-1:0]   div_ff;
   logic               done_ff;

   logic [WIDTH:0]     partial;
   logic [WIDTH:0]     diff;
   logic [WIDTH-1:0]   rem_in;
   logic [WIDTH-1:0]   quo_in;

   // one restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      partial = {rem_ff, quo_ff[WIDTH-1]};
      diff    = partial - {1'b0, div_ff};
      if (!diff[WIDTH]) begin
         rem_in = diff[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], 1'b1};
      end else begin
         rem_in = partial[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], 1'b0};
      end
   end

   // sequencing of the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DIV_IDLE: begin
               if (ctrl.start) begin
                  rem_ff   <= '0;
                  quo_ff   <= dividend;
                  div_ff   <= divisor;
                  cnt_ff   <= CNT_W'(WIDTH);
                  state_ff <= DIV_RUN;
               end
            end
            DIV_RUN: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end
            end
            default: state_ff <= DIV_IDLE;
         endcase
      end
   end

   assign status.busy = (state_ff == DIV_RUN);
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

@@ rtl/core/trial_division_prime_test.sv @@
// trial_division_prime_test: sequencer that tests one integer for primality
`timescale 1ns / 1ps
//
// Usage: an item on the req_ channel carries one signed DATA_WIDTH-bit
// candidate. The block answers with one item on the rsp_ channel whose
// rsp_is_prime bit is 1 when the candidate is prime. Values of 1 or less
// are rejected at once, with no division: the answer goes straight to DELIVER.
// Larger values are tried against divisors d = 2, 3, ... while d <= n / d.
// Each divisor takes one pass through the one shared restoring
// divider, which yields quotient (for the bound) and remainder (for the
// test) together. For 32 bits the worst case is about 46340 divisors.
// One item is in work at a time: req_stall is high from acceptance
// until the sequencer returns to idle.
// The answer sits in an output register; a stall on rsp_ holds it, and a
// new item may be accepted while it waits. A finished answer that finds the
// output register still full waits until that one is taken.
// Reset (synchronous, active high) returns to idle with no answer pending.
//
module trial_division_prime_test #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_candidate,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_is_prime
);
   import tdpt_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      START_DIV,
      WAIT_DIV,
      DELIVER
   } state_type;

   state_type                state_ff;
   logic [DATA_WIDTH-1:0]    value_ff;
   logic [DATA_WIDTH-1:0]    d_ff;
   logic                     verdict_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_is_prime_ff;

   tdpt_div_ctrl_type        div_ctrl;
   tdpt_div_status_type      div_status;
   logic [DATA_WIDTH-1:0]    div_quo;
   logic [DATA_WIDTH-1:0]    div_rem;

   logic                     req_accept;
   logic                     out_free;

   assign req_accept     = req_valid && !req_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign req_stall      = (state_ff != IDLE);
   assign div_ctrl.start = (state_ff == START_DIV);

   // shared divider: value / d and value % d
   tdpt_divider #(
      .WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (value_ff),
      .divisor   (d_ff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // answer taken, unless a new one is loaded in its place
         if (rsp_valid_ff && !rsp_stall && (state_ff != DELIVER)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  value_ff <= req_candidate;
                  d_ff     <= DATA_WIDTH'(2);
                  // negative, zero and one are never prime
                  if (req_candidate[DATA_WIDTH-1] ||
                      (req_candidate[DATA_WIDTH-1:1] == '0)) begin
                     verdict_ff <= 1'b0;
                     state_ff   <= DELIVER;
                  end else begin
                     state_ff <= START_DIV;
                  end
               end
            end
            START_DIV: begin
               state_ff <= WAIT_DIV;
            end
            WAIT_DIV: begin
               if (div_status.done) begin
                  if (d_ff > div_quo) begin
                     // bound passed with no divisor found
                     verdict_ff <= 1'b1;
                     state_ff   <= DELIVER;
                  end else if (div_rem == '0) begin
                     verdict_ff <= 1'b0;
                     state_ff   <= DELIVER;
                  end else begin
                     d_ff     <= d_ff + 1'b1;
                     state_ff <= START_DIV;
                  end
               end
            end
            DELIVER: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_is_prime_ff <= verdict_ff;
                  state_ff        <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // an accepted item closes the input until its answer is loaded
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input open right after an accepted item");

   // divider results arrive only while the sequencer waits for them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == WAIT_DIV))
      else $error("divider finished outside the wait state");

   // the divider runs only while the sequencer waits for it
   a_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == WAIT_DIV))
      else $error("divider running outside the wait state");

   // trial divisors start at two
   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == START_DIV) |-> (d_ff >= DATA_WIDTH'(2)))
      else $error("trial divisor below two");

   // a delivered answer shows up on the output the next cycle
   a_deliver_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == DELIVER) && out_free) |=> rsp_valid)
      else $error("answer not loaded into the output register");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for the trial division prime test
`timescale 1ns / 1ps

module tb;

   localparam int W = 32;
   localparam int N_PROBES = 20;
   localparam int N_RANDOM = 100;
   localparam int N_QUIET = 15;
   localparam int HOLD_CYCLES = 3000;
   localparam int PAUSE_AT = 50;
   localparam int TINY_ITEMS = 8;
   localparam int DRAIN_CYCLES = 200;

   // one row of the directed probe table
   typedef struct packed {
      logic signed [W-1:0] cand;
      logic                known;
      logic                want;
   } probe_row_type;

   // one answer still owed by the block
   typedef struct {
      logic signed [W-1:0] cand;
      logic                is_prime;
   } verdict_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [W-1:0] req_candidate = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_is_prime;

   // handshake state sampled at the falling edge, used at the next rising edge
   bit       req_take = 1'b0;
   bit       rsp_take = 1'b0;
   logic     rsp_bit;

   bit          quiet = 1'b0;
   bit          hold_ask = 1'b0;
   int          mismatches = 0;
   verdict_type pending_verdicts [$];

   // directed probes: known answers typed in, the rest left to the predictor
   probe_row_type probe_rows [0:N_PROBES-1] = '{
      '{32'sh8000_0000, 1'b1, 1'b0},
      '{-32'sd1,        1'b1, 1'b0},
      '{32'sd0,         1'b1, 1'b0},
      '{32'sd1,         1'b1, 1'b0},
      '{32'sd2,         1'b1, 1'b1},
      '{32'sd3,         1'b1, 1'b1},
      '{32'sd4,         1'b1, 1'b0},
      '{32'sh7FFF_FFFE, 1'b1, 1'b0},
      '{32'sd5,         1'b0, 1'b0},
      '{32'sd9,         1'b0, 1'b0},
      '{32'sd25,        1'b0, 1'b0},
      '{32'sd49,        1'b0, 1'b0},
      '{32'sd97,        1'b0, 1'b0},
      '{32'sd121,       1'b0, 1'b0},
      '{32'sd65521,     1'b0, 1'b0},
      '{32'sd1000003,   1'b0, 1'b0},
      '{32'sh4000_0000, 1'b0, 1'b0},
      '{32'sh5555_5555, 1'b0, 1'b0},
      '{32'sh7FFF_FFFD, 1'b0, 1'b0},
      '{32'sh7FFF_FFFF, 1'b1, 1'b1}
   };

   trial_division_prime_test #(
      .DATA_WIDTH(W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // safety net on total run time
   initial begin
      #30_000_000;
      $display("trial_division_prime_test test failed");
      $finish;
   end

   // primality by trial division, bound kept as d <= n / d
   function automatic logic prime_verdict(logic signed [W-1:0] cand);
      logic [W-1:0] n;
      logic [W-1:0] d;
      if (cand <= 1) begin
         return 1'b0;
      end
      n = cand;
      for (d = 2; d <= n / d; d++) begin
         if (n % d == 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // random candidate: mostly cheap values, some full-width quick rejects
   function automatic logic signed [W-1:0] pick_candidate(bit tiny);
      logic [W-1:0] r;
      int unsigned  f;
      r = $urandom;
      if (tiny) begin
         return $urandom_range(0, 255);
      end
      case ($urandom_range(0, 9))
         0: begin
            r[W-1] = 1'b1;
         end
         1, 2, 3, 4: begin
            r = $urandom_range(0, 16383);
         end
         5: begin
            r = $urandom_range(16384, 262143);
         end
         6, 7: begin
            r[W-1] = 1'b0;
            r[0] = 1'b0;
         end
         default: begin
            // multiple of a small odd factor, so the divisor search stops early
            f = 2 * $urandom_range(1, 6) + 1;
            r = f * $urandom_range(1, 32'h7FFF_FFFF / f);
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // offer one item, wait for it to be taken, then log the owed answer
   task automatic offer_item(input logic signed [W-1:0] cand, input bit known,
                             input bit want);
      int          n;
      verdict_type v;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_candidate <= cand;
      do @(posedge clock); while (!req_take);
      v.cand = cand;
      v.is_prime = known ? want : prime_verdict(cand);
      pending_verdicts.push_back(v);
   endtask

   // sample both handshakes away from the active edge
   always @(negedge clock) begin
      req_take = !reset && req_valid && req_stall === 1'b0;
      rsp_take = !reset && rsp_valid === 1'b1 && !rsp_stall;
      rsp_bit = rsp_is_prime;
   end

   // compare each answer with the oldest one owed
   always @(posedge clock) begin
      verdict_type v;
      if (rsp_take) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected answer is_prime=%b", rsp_bit));
         end else begin
            v = pending_verdicts.pop_front();
            if (rsp_bit !== v.is_prime) begin
               report_mismatch($sformatf("candidate %0d: is_prime=%b, want %b",
                                         v.cand, rsp_bit, v.is_prime));
            end
         end
      end
   end

   // receiver stalls: random bursts, one long hold-off, none at the end
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_stall <= 1'b1;
            n = HOLD_CYCLES;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 11);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 20);
         end
         repeat (n) @(posedge clock);
      end
   end

   // reset, directed probes, random items, drain and verdict
   initial begin
      int i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed probes
      for (i = 0; i < N_PROBES; i++) begin
         offer_item(probe_rows[i].cand, probe_rows[i].known, probe_rows[i].want);
      end

      // let the probes finish, then start the long hold-off before the tiny items
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      hold_ask = 1'b1;
      while (hold_ask) @(posedge clock);

      // random items; receiver holds off at the start while tiny items fill the block
      for (i = 0; i < N_RANDOM; i++) begin
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            while (pending_verdicts.size() != 0) @(posedge clock);
         end
         if (i == N_RANDOM - N_QUIET) begin
            quiet = 1'b1;
         end
         offer_item(pick_candidate(i < TINY_ITEMS), 1'b0, 1'b0);
      end
      req_valid <= 1'b0;

      // drain, then allow time for any stray answer
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("trial_division_prime_test test passed");
      end else begin
         $display("trial_division_prime_test test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_divider.sv
rtl/core/trial_division_prime_test.sv
tb/tb.sv
